// File: rtl/plp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plp_pkg: shared types and constants of the piecewise linear profile unit
// Field widths, request and status codes, table entry layout, controller
// states and the divider handoff.
// ----------------------------------------------------------------------------
package plp_pkg;

	// Field widths.
	localparam int TIME_W   = 16;
	localparam int TEMP_W   = 20;
	localparam int INDEX_W  = 4;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	// Default table depth.
	localparam int MAX_POINTS_DEF = 16;

	// Reset value of the active point count.
	localparam logic [COUNT_W-1:0] POINTS_RESET = 5'd2;

	// Arithmetic widths: temperature difference, time difference, product.
	localparam int DY_W   = TEMP_W + 1;
	localparam int DT_W   = TIME_W + 1;
	localparam int PROD_W = DY_W + DT_W;
	// Product magnitude is below 2^20 * 2^16, so 36 bits hold it.
	localparam int MAG_W  = TEMP_W + TIME_W;

	// Saturation limits of the temperature field.
	localparam logic signed [PROD_W-1:0] TEMP_MIN = -(PROD_W'(1) <<< (TEMP_W - 1));
	localparam logic signed [PROD_W-1:0] TEMP_MAX = (PROD_W'(1) <<< (TEMP_W - 1)) - 1;

	// Request codes.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_INTERP = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_HELD   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_WRITE  = 2'd2;

	// One breakpoint as stored in the table.
	typedef struct packed {
		logic        [TIME_W-1:0] pt_time;
		logic signed [TEMP_W-1:0] pt_temp;
	} entry_t;

	// Divider result handoff.
	typedef struct packed {
		logic             done;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} div_result_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_RESULT
	} state_t;

endpackage : plp_pkg
`default_nettype wire

// File: rtl/plp_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plp_table: breakpoint table
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module plp_table #(
	parameter int DEPTH = plp_pkg::MAX_POINTS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire [AW-1:0]         waddr,
	input  wire plp_pkg::entry_t wdata,
	input  wire [AW-1:0]         raddr,
	output plp_pkg::entry_t      rdata
);
	import plp_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule : plp_table
`default_nettype wire

// File: rtl/plp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plp_div: iterative signed divider
// Restoring division of magnitudes, one quotient bit per cycle. The quotient
// truncates toward zero; the sign is returned beside the magnitude.
// ----------------------------------------------------------------------------
module plp_div (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     start,
	input  wire signed [plp_pkg::PROD_W-1:0]        dividend,
	input  wire signed [plp_pkg::DT_W-1:0]          divisor,
	output plp_pkg::div_result_t                    result
);
	import plp_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic                neg_q;
	logic [MAG_W-1:0]    quo_q;
	logic [TIME_W:0]     rem_q;
	logic [TIME_W-1:0]   dmag_q;

	logic [PROD_W-1:0]   nabs;
	logic [DT_W-1:0]     dabs;
	logic [TIME_W:0]     rem_sh;
	logic                fits;

	// Operand magnitudes.
	assign nabs = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
	assign dabs = divisor[DT_W-1] ? DT_W'(-divisor) : DT_W'(divisor);

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign rem_sh = {rem_q[TIME_W-1:0], quo_q[MAG_W-1]};
	assign fits   = (rem_sh >= {1'b0, dmag_q});

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the shift and subtract loop.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= nabs[MAG_W-1:0];
			rem_q  <= '0;
			dmag_q <= dabs[TIME_W-1:0];
			neg_q  <= dividend[PROD_W-1] ^ divisor[DT_W-1];
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[MAG_W-2:0], fits};
			rem_q <= fits ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
		end
	end

	assign result.done = done_q;
	assign result.neg  = neg_q;
	assign result.mag  = quo_q;

endmodule : plp_div
`default_nettype wire

// File: rtl/piecewise_linear_profile_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_profile_unit: temperature setpoint profile generator
// Loads breakpoints into a table and answers time queries by linear
// interpolation along the first segment that ends at or after the query.
// ----------------------------------------------------------------------------
// The unit handles one item at a time. A breakpoint write goes from idle
// straight to the result state. A query reads one table entry per cycle,
// starting at the first point, until it reaches the segment that covers
// the query time; it then registers the product in the multiply state,
// starts the bit-serial divider (36 quotient steps) and waits for its
// quotient. A query past the last point, or one that lands on a zero-length
// segment, needs only the table walk. The result sits in an output
// register, so a finished result that waits for the consumer does not
// block the next input transfer from being taken once the unit is back
// to idle.
// ----------------------------------------------------------------------------
module piecewise_linear_profile_unit #(
	parameter int MAX_POINTS = plp_pkg::MAX_POINTS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// Configuration write channel.
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [plp_pkg::COUNT_W-1:0]            points_in_use,
	// Input channel.
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   req_type,
	input  wire [plp_pkg::INDEX_W-1:0]            point_index,
	input  wire [plp_pkg::TIME_W-1:0]             point_time,
	input  wire signed [plp_pkg::TEMP_W-1:0]      point_temp,
	input  wire [plp_pkg::TIME_W-1:0]             query_time,
	// Output channel.
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic signed [plp_pkg::TEMP_W-1:0]     temperature,
	output logic [plp_pkg::STATUS_W-1:0]          status
);
	import plp_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]         points_q;
	logic [AW-1:0]              last_idx;
	logic [AW-1:0]              idx_q;
	logic [TIME_W-1:0]          query_q;
	logic [TIME_W-1:0]          prev_time_q;
	logic signed [TEMP_W-1:0]   prev_temp_q;
	logic signed [DY_W-1:0]     dy_q;
	logic signed [DT_W-1:0]     dt_q;
	logic signed [DT_W-1:0]     den_q;
	logic signed [PROD_W-1:0]   prod_c;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [PROD_W-1:0]   sum_q;
	logic [STATUS_W-1:0]        res_status_q;

	logic                       out_valid_q;
	logic signed [TEMP_W-1:0]   temperature_q;
	logic [STATUS_W-1:0]        status_q;

	logic                       in_xfer;
	logic                       out_free;
	logic                       covers;
	logic                       slot_ok;
	logic                       tbl_we;
	logic [AW-1:0]              tbl_raddr;
	entry_t                     tbl_wdata;
	entry_t                     tbl_rdata;
	logic                       div_start;
	div_result_t                div_res;
	logic signed [PROD_W-1:0]   quo_signed;

	// Saturate a wide sum to the temperature range.
	function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [PROD_W-1:0] v);
		if (v < TEMP_MIN) begin
			return TEMP_MIN[TEMP_W-1:0];
		end else if (v > TEMP_MAX) begin
			return TEMP_MAX[TEMP_W-1:0];
		end else begin
			return v[TEMP_W-1:0];
		end
	endfunction

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= POINTS_RESET;
		end else if (cfg_valid) begin
			points_q <= points_in_use;
		end
	end

	// Index of the last active point, with the count clamped to the table.
	always_comb begin
		if (32'(points_q) <= 32'd2) begin
			last_idx = AW'(1);
		end else if (32'(points_q) >= MAX_POINTS) begin
			last_idx = AW'(MAX_POINTS - 1);
		end else begin
			last_idx = AW'(points_q - 5'd1);
		end
	end

	// Handshake helpers.
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign slot_ok  = (32'(point_index) < MAX_POINTS);
	assign covers   = (query_q <= tbl_rdata.pt_time);

	// Breakpoint table.
	assign tbl_we              = in_xfer && (req_type == REQ_WRITE) && slot_ok;
	assign tbl_wdata.pt_time   = point_time;
	assign tbl_wdata.pt_temp   = point_temp;
	assign tbl_raddr           = (state_q == ST_IDLE) ? '0 : AW'(idx_q + 1'b1);

	plp_table #(
		.DEPTH (MAX_POINTS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(point_index)),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// Divider for the interpolation quotient.
	plp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (den_q),
		.result   (div_res)
	);

	assign quo_signed = div_res.neg ? -PROD_W'(div_res.mag) : PROD_W'(div_res.mag);
	assign prod_c     = dy_q * dt_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (req_type == REQ_WRITE) ? ST_RESULT : ST_READ;
				end
			end
			ST_READ: begin
				if (idx_q != '0) begin
					if (covers) begin
						state_d = (tbl_rdata.pt_time == prev_time_q) ? ST_RESULT : ST_MUL;
					end else if (idx_q == last_idx) begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_MUL:    state_d = ST_START;
			ST_START:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_START: div_start = 1'b1;
			default: begin
				in_ready  = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Segment walk, difference terms, product and sum.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q        <= '0;
				query_q      <= query_time;
				sum_q        <= '0;
				res_status_q <= STATUS_WRITE;
			end
			ST_READ: begin
				if (idx_q == '0 || (!covers && idx_q != last_idx)) begin
					prev_time_q <= tbl_rdata.pt_time;
					prev_temp_q <= tbl_rdata.pt_temp;
					idx_q       <= AW'(idx_q + 1'b1);
				end else if (covers) begin
					// Covering segment: set up the difference terms; a zero-length segment returns its end temperature.
					sum_q        <= PROD_W'(tbl_rdata.pt_temp);
					res_status_q <= STATUS_INTERP;
					dy_q  <= DY_W'(tbl_rdata.pt_temp) - DY_W'(prev_temp_q);
					dt_q  <= $signed({1'b0, query_q}) - $signed({1'b0, prev_time_q});
					den_q <= $signed({1'b0, tbl_rdata.pt_time}) - $signed({1'b0, prev_time_q});
				end else begin
					// Past the last point: hold its temperature.
					sum_q        <= PROD_W'(tbl_rdata.pt_temp);
					res_status_q <= STATUS_HELD;
				end
			end
			ST_MUL: begin
				prod_q <= prod_c;
			end
			ST_DIV: begin
				if (div_res.done) begin
					sum_q <= PROD_W'(prev_temp_q) + quo_signed;
				end
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			temperature_q <= sat_temp(sum_q);
			status_q      <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign temperature = temperature_q;
	assign status      = status_q;

endmodule : piecewise_linear_profile_unit
`default_nettype wire

// File: rtl/plp_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plp_check: port-level checks of the profile unit
// Watches the top-level ports and flags result and handshake slips.
// ----------------------------------------------------------------------------
module plp_check (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_valid,
	input wire                                 in_ready,
	input wire                                 out_valid,
	input wire                                 out_ready,
	input wire signed [plp_pkg::TEMP_W-1:0]    temperature,
	input wire [plp_pkg::STATUS_W-1:0]         status
);
	import plp_pkg::*;

	// A pending result stays offered until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before its transfer");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(temperature) && $stable(status))
		else $error("result payload changed while stalled");

	// Only defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_INTERP || status == STATUS_HELD ||
			status == STATUS_WRITE))
		else $error("undefined status code");

	// A write result carries a zero temperature.
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_WRITE |-> temperature == '0)
		else $error("write result with nonzero temperature");

	// After a transfer in_ready drops, since the unit is busy with that item.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transfer");

endmodule : plp_check

bind piecewise_linear_profile_unit plp_check u_plp_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.temperature (temperature),
	.status      (status)
);
`default_nettype wire
